FILE: src/triggered_breakpoint_envelope_defines.svh
// assertion macros for the triggered breakpoint envelope
// clocked on clock, disabled while reset is high
`ifndef TRIGGERED_BREAKPOINT_ENVELOPE_DEFINES_SVH
`define TRIGGERED_BREAKPOINT_ENVELOPE_DEFINES_SVH

// condition holds at every edge out of reset
`define TBE_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TBE_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: src/tbe_pkg.sv
// types, constants and helpers shared by the breakpoint envelope modules
// no dependencies
package tbe_pkg;

   localparam int MAX_POINTS       = 32;
   localparam int IDX_W            = $clog2(MAX_POINTS);
   localparam int SEG_W            = 5;
   localparam int ENTRY_W          = 5;
   localparam int LEVEL_W          = 32;
   localparam int LEN_W            = 32;
   localparam int STEP_W           = 32;
   localparam int FACTOR_FRAC_BITS = 24;
   localparam int PROD_W           = LEVEL_W + STEP_W;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 5;

   localparam logic [CSR_INDEX_W-1:0] REG_EXP_MODE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_SEG_COUNT = CSR_INDEX_W'(1);

   localparam logic             ACTION_LOAD = 1'b0;
   localparam logic             ACTION_TICK = 1'b1;

   localparam logic [IDX_W-1:0] LAST_SEG  = IDX_W'(MAX_POINTS - 1);
   localparam logic [IDX_W-1:0] HEAD_ADDR = '0;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_LOAD_HEAD,
      CMD_TICK,
      CMD_RESTART
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [IDX_W-1:0]  addr;
      logic [LEVEL_W-1:0] point;
      logic [LEN_W-1:0]  length;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] point;
      logic [LEN_W-1:0]   length;
      logic [STEP_W-1:0]  step;
   } row_type;

   typedef struct packed {
      logic             exp_mode;
      logic [SEG_W-1:0] seg_count;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic pop;
      logic result_load;
   } back_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RST_APPLY,
      ST_CHECK,
      ST_SKIP_APPLY,
      ST_STEP,
      ST_ROUND,
      ST_STEP_END,
      ST_SNAP,
      ST_RESULT
   } back_state_type;

endpackage

FILE: src/tbe_front.sv
// front end: classifies incoming items into back-end commands
// depends on tbe_pkg
module tbe_front
   import tbe_pkg::*;
(
   input  logic                      push,
   input  logic                      req_action,
   input  logic                      req_restart,
   input  logic [ENTRY_W-1:0]        req_entry_index,
   input  logic signed [LEVEL_W-1:0] req_point_value,
   input  logic [LEN_W-1:0]          req_segment_length,
   input  logic signed [STEP_W-1:0]  req_segment_step,
   input  queue_status_type          q_status,
   output logic                      q_push,
   output cmd_type                   q_cmd
);

   logic in_range;

   assign in_range = 32'(req_entry_index) < MAX_POINTS;
   assign q_push   = push && !q_status.full;

   always_comb begin
      q_cmd.addr   = IDX_W'(req_entry_index);
      q_cmd.point  = req_point_value;
      q_cmd.length = req_segment_length;
      q_cmd.step   = req_segment_step;
      if (req_action == ACTION_TICK) begin
         q_cmd.kind = req_restart ? CMD_RESTART : CMD_TICK;
      end else if (!in_range) begin
         q_cmd.kind = CMD_NOP;
      end else if (IDX_W'(req_entry_index) == HEAD_ADDR) begin
         q_cmd.kind = CMD_LOAD_HEAD;
      end else begin
         q_cmd.kind = CMD_LOAD;
      end
   end

endmodule

FILE: src/tbe_queue.sv
// short command queue between front and back ends
// depends on tbe_pkg
module tbe_queue
   import tbe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             q_push,
   input  cmd_type          q_cmd_in,
   input  logic             q_pop,
   output cmd_type          q_cmd_out,
   output queue_status_type q_status
);

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign q_status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;
   assign do_push        = q_push && !q_status.full;
   assign do_pop         = q_pop && !q_status.empty;
   assign q_cmd_out      = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= q_cmd_in;
      end
   end

endmodule

FILE: src/tbe_back.sv
// back end: breakpoint table, envelope state, step arithmetic and result register
// depends on tbe_pkg
module tbe_back
   import tbe_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  queue_status_type          q_status,
   input  cmd_type                   q_cmd,
   input  logic                      pop,
   output logic                      empty,
   output logic signed [LEVEL_W-1:0] rsp_output_value,
   output logic                      rsp_is_playing,
   output logic [SEG_W-1:0]          rsp_current_segment,
   output back_status_type           back_status
);

   row_type                    table_mem [MAX_POINTS];
   row_type                    rd_ff;
   logic [IDX_W-1:0]           rd_addr;
   logic                       wr_en;

   back_state_type             state_ff, state_in;
   cmd_type                    cmd_ff, cmd_in;
   logic                       running_ff, running_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [LEN_W-1:0]           left_ff, left_in;
   logic signed [LEVEL_W-1:0]  level_ff, level_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [LEVEL_W-1:0]  out_value_ff, out_value_in;
   logic                       out_playing_ff, out_playing_in;
   logic [SEG_W-1:0]           out_seg_ff, out_seg_in;

   logic [IDX_W-1:0]           seg_n;
   logic [IDX_W-1:0]           idx_next;
   logic                       slot_free;
   logic signed [LEVEL_W:0]    lin_sum;
   logic signed [LEVEL_W-1:0]  lin_sat;
   logic signed [PROD_W-1:0]   biased;
   logic signed [PROD_W-1:0]   shifted;
   logic signed [LEVEL_W-1:0]  exp_sat;

   assign seg_n     = (32'(cfg.seg_count) > MAX_POINTS - 1) ? LAST_SEG
                                                            : IDX_W'(cfg.seg_count);
   assign idx_next  = idx_ff + 1'b1;
   assign slot_free = !rsp_valid_ff || pop;

   // saturating add
   assign lin_sum = {level_ff[LEVEL_W-1], level_ff} + {rd_ff.step[STEP_W-1], rd_ff.step};
   always_comb begin
      if (lin_sum[LEVEL_W] != lin_sum[LEVEL_W-1]) begin
         lin_sat = lin_sum[LEVEL_W] ? {1'b1, {(LEVEL_W-1){1'b0}}} : {1'b0, {(LEVEL_W-1){1'b1}}};
      end else begin
         lin_sat = lin_sum[LEVEL_W-1:0];
      end
   end

   // round half up, shift out factor fraction, saturate
   assign biased  = prod_ff + (PROD_W'(1) <<< (FACTOR_FRAC_BITS - 1));
   assign shifted = biased >>> FACTOR_FRAC_BITS;
   always_comb begin
      if (shifted[PROD_W-1:LEVEL_W-1] != '0 && shifted[PROD_W-1:LEVEL_W-1] != '1) begin
         exp_sat = shifted[PROD_W-1] ? {1'b1, {(LEVEL_W-1){1'b0}}}
                                     : {1'b0, {(LEVEL_W-1){1'b1}}};
      end else begin
         exp_sat = shifted[LEVEL_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (cmd_ff.kind)
               CMD_TICK:    state_in = ST_CHECK;
               CMD_RESTART: state_in = ST_RST_APPLY;
               default:     state_in = ST_RESULT;
            endcase
         end
         ST_RST_APPLY:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (!running_ff) begin
               state_in = ST_RESULT;
            end else if (left_ff == '0 && idx_ff < seg_n) begin
               state_in = ST_SKIP_APPLY;
            end else if (idx_ff < seg_n) begin
               state_in = ST_STEP;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_SKIP_APPLY: state_in = ST_CHECK;
         ST_STEP:       state_in = cfg.exp_mode ? ST_ROUND : ST_STEP_END;
         ST_ROUND:      state_in = ST_STEP_END;
         ST_STEP_END:   state_in = (left_ff == '0) ? ST_SNAP : ST_RESULT;
         ST_SNAP:       state_in = ST_RESULT;
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd_in                  = cmd_ff;
      running_in              = running_ff;
      idx_in                  = idx_ff;
      left_in                 = left_ff;
      level_in                = level_ff;
      prod_in                 = prod_ff;
      rd_addr                 = idx_ff;
      wr_en                   = 1'b0;
      back_status.pop         = 1'b0;
      back_status.result_load = 1'b0;
      rsp_valid_in            = rsp_valid_ff && !pop;
      out_value_in            = out_value_ff;
      out_playing_in          = out_playing_ff;
      out_seg_in              = out_seg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               back_status.pop = 1'b1;
               cmd_in          = q_cmd;
            end
         end
         ST_EXEC: begin
            case (cmd_ff.kind)
               CMD_LOAD: begin
                  wr_en = 1'b1;
               end
               CMD_LOAD_HEAD: begin
                  wr_en      = 1'b1;
                  running_in = 1'b0;
                  idx_in     = '0;
                  left_in    = '0;
                  level_in   = cmd_ff.point;
               end
               CMD_RESTART: begin
                  rd_addr = HEAD_ADDR;
               end
               default: ;
            endcase
         end
         ST_RST_APPLY: begin
            idx_in     = '0;
            left_in    = rd_ff.length;
            level_in   = rd_ff.point;
            running_in = 1'b1;
         end
         ST_CHECK: begin
            if (running_ff) begin
               if (left_ff == '0 && idx_ff < seg_n) begin
                  rd_addr = idx_next;
               end else if (idx_ff < seg_n) begin
                  rd_addr = idx_ff;
               end else begin
                  running_in = 1'b0;
               end
            end
         end
         ST_SKIP_APPLY: begin
            level_in = rd_ff.point;
            idx_in   = idx_next;
            if (idx_next < seg_n) begin
               left_in = rd_ff.length;
            end
         end
         ST_STEP: begin
            left_in = left_ff - 1'b1;
            if (cfg.exp_mode) begin
               prod_in = PROD_W'(level_ff) * PROD_W'($signed(rd_ff.step));
            end else begin
               level_in = lin_sat;
            end
         end
         ST_ROUND: begin
            level_in = exp_sat;
         end
         ST_STEP_END: begin
            rd_addr = idx_next;
         end
         ST_SNAP: begin
            level_in = rd_ff.point;
         end
         ST_RESULT: begin
            if (slot_free) begin
               back_status.result_load = 1'b1;
               rsp_valid_in            = 1'b1;
               out_value_in            = level_ff;
               out_playing_in          = running_ff;
               out_seg_in              = SEG_W'(idx_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         running_ff   <= 1'b0;
         idx_ff       <= '0;
         left_ff      <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         running_ff   <= running_in;
         idx_ff       <= idx_in;
         left_ff      <= left_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      prod_ff        <= prod_in;
      out_value_ff   <= out_value_in;
      out_playing_ff <= out_playing_in;
      out_seg_ff     <= out_seg_in;
   end

   // breakpoint table
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[cmd_ff.addr] <= '{point: cmd_ff.point, length: cmd_ff.length,
                                     step: cmd_ff.step};
      end
      rd_ff <= table_mem[rd_addr];
   end

   assign empty               = !rsp_valid_ff;
   assign rsp_output_value    = out_value_ff;
   assign rsp_is_playing      = out_playing_ff;
   assign rsp_current_segment = out_seg_ff;

endmodule

FILE: src/triggered_breakpoint_envelope.sv
// top level of the triggered breakpoint envelope generator
// depends on tbe_pkg, tbe_front, tbe_queue, tbe_back and the assertion macro header
`include "triggered_breakpoint_envelope_defines.svh"

// Envelope generator over a table of up to 32 breakpoints, linear or exponential
// segments, restart on trigger. Every accepted item gives exactly one result.
// Items go through a two-entry command queue into a back-end sequencer that works
// on one item at a time, so a new item is taken while the previous one is still
// being processed and while its result waits in the output register. A load
// passes exec and result; a tick passes exec, check and result when stopped, and
// adds step and step-end when stepping, round in exponential mode after the
// registered 32 by 32 multiply, restart-apply for a restart, snap when a segment
// ends and the level snaps to its endpoint, and skip-apply plus check for each
// zero-length segment skipped. Configuration writes are always ready and must be
// made only while the block is idle. The breakpoint table is not cleared by reset.
module triggered_breakpoint_envelope
   import tbe_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_action,
   input  logic                      req_restart,
   input  logic [ENTRY_W-1:0]        req_entry_index,
   input  logic signed [LEVEL_W-1:0] req_point_value,
   input  logic [LEN_W-1:0]          req_segment_length,
   input  logic signed [STEP_W-1:0]  req_segment_step,
   output logic                      empty,
   input  logic                      pop,
   output logic signed [LEVEL_W-1:0] rsp_output_value,
   output logic                      rsp_is_playing,
   output logic [SEG_W-1:0]          rsp_current_segment,
   input  logic                      valid,
   output logic                      ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   cfg_type          cfg_ff, cfg_in;
   queue_status_type q_status;
   back_status_type  back_status;
   cmd_type          front_cmd;
   cmd_type          head_cmd;
   logic             q_push;

   assign ready = 1'b1;
   assign full  = q_status.full;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid && ready) begin
         case (csr_index)
            REG_EXP_MODE:  cfg_in.exp_mode  = csr_data[0];
            REG_SEG_COUNT: cfg_in.seg_count = SEG_W'(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.exp_mode  <= 1'b0;
         cfg_ff.seg_count <= SEG_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tbe_front u_front (
      .push               (push),
      .req_action         (req_action),
      .req_restart        (req_restart),
      .req_entry_index    (req_entry_index),
      .req_point_value    (req_point_value),
      .req_segment_length (req_segment_length),
      .req_segment_step   (req_segment_step),
      .q_status           (q_status),
      .q_push             (q_push),
      .q_cmd              (front_cmd)
   );

   tbe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .q_push    (q_push),
      .q_cmd_in  (front_cmd),
      .q_pop     (back_status.pop),
      .q_cmd_out (head_cmd),
      .q_status  (q_status)
   );

   tbe_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .q_status            (q_status),
      .q_cmd               (head_cmd),
      .pop                 (pop),
      .empty               (empty),
      .rsp_output_value    (rsp_output_value),
      .rsp_is_playing      (rsp_is_playing),
      .rsp_current_segment (rsp_current_segment),
      .back_status         (back_status)
   );

   `TBE_ASSERT_ALWAYS(a_queue_not_full_and_empty, !(q_status.full && q_status.empty), "queue full and empty")
   `TBE_ASSERT_IMPLIES(a_pop_needs_item, back_status.pop, !q_status.empty, "back end pops empty queue")
   `TBE_ASSERT_IMPLIES(a_result_slot_free, back_status.result_load, empty || pop, "result overwritten")

endmodule
